// File: sv/cpv_pkg.sv
// shared types and constants of the codon profile viterbi column block
package cpv_pkg;

    // operation codes carried on the input tuser
    localparam logic [2:0] OP_MATCH_WR = 3'd0;
    localparam logic [2:0] OP_INSERT_WR = 3'd1;
    localparam logic [2:0] OP_TRANS_WR = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_CODON = 3'd4;

    // alphabet and transition kinds
    localparam int N_AA = 20;
    localparam int N_TK = 7;
    localparam logic [4:0] AA_STOP = 5'd20;

    localparam int TK_MM = 0;
    localparam int TK_IM = 1;
    localparam int TK_DM = 2;
    localparam int TK_MI = 3;
    localparam int TK_II = 4;
    localparam int TK_MD = 5;
    localparam int TK_DD = 6;

    // standard genetic code, index is first*16 + second*4 + third
    localparam logic [4:0] GENETIC_CODE [64] = '{
        5'd8, 5'd11, 5'd8, 5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
        5'd14, 5'd15, 5'd14, 5'd15, 5'd7, 5'd7, 5'd10, 5'd7,
        5'd13, 5'd6, 5'd13, 5'd6, 5'd12, 5'd12, 5'd12, 5'd12,
        5'd14, 5'd14, 5'd14, 5'd14, 5'd9, 5'd9, 5'd9, 5'd9,
        5'd3, 5'd2, 5'd3, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd17, 5'd17, 5'd17, 5'd17,
        5'd20, 5'd19, 5'd20, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15,
        5'd20, 5'd1, 5'd18, 5'd1, 5'd9, 5'd4, 5'd9, 5'd4
    };

    // control of the shared add/max unit
    typedef struct packed {
        logic en;
        logic use_max;
    } alu_ctl_t;

endpackage

// File: sv/cpv_ram.sv
// generic single write, single read memory with registered read data
module cpv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/cpv_alu.sv
// shared saturating adder with running maximum accumulator
module cpv_alu #(
    parameter int SCORE_BITS = 32
) (
    input  logic                         clk,
    input  cpv_pkg::alu_ctl_t            ctl,
    input  logic signed [SCORE_BITS-1:0] a,
    input  logic signed [SCORE_BITS-1:0] b,
    output logic signed [SCORE_BITS-1:0] acc
);

    localparam logic signed [SCORE_BITS-1:0] SC_NEG_INF = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam logic signed [SCORE_BITS-1:0] SC_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

    logic signed [SCORE_BITS:0]   sum;
    logic signed [SCORE_BITS-1:0] sat;
    logic signed [SCORE_BITS-1:0] acc_reg;
    logic signed [SCORE_BITS-1:0] acc_next;

    // saturating add, minus infinity absorbs
    always_comb
    begin
        sum = (SCORE_BITS+1)'(a) + (SCORE_BITS+1)'(b);
        if (a == SC_NEG_INF || b == SC_NEG_INF)
        begin
            sat = SC_NEG_INF;
        end
        else if (sum < (SCORE_BITS+1)'(SC_NEG_INF))
        begin
            sat = SC_NEG_INF;
        end
        else if (sum > (SCORE_BITS+1)'(SC_MAX))
        begin
            sat = SC_MAX;
        end
        else
        begin
            sat = SCORE_BITS'(sum);
        end
    end

    // keep the older value only when strictly larger
    always_comb
    begin
        if (ctl.use_max && (acc_reg > sat))
        begin
            acc_next = acc_reg;
        end
        else
        begin
            acc_next = sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: sv/codon_profile_viterbi_column.sv
// top level: codon translation and profile hmm viterbi column sequencer
// A codon beat runs one Viterbi column over the profile, one position at a time, through a
// single saturating add/max unit that does nine operations per position. A stop codon, an
// unknown op or a table write goes straight to the output stage. After reset and after each
// restart beat the match, insert and delete rows are swept back to their start values, while
// no input beat is taken. The input is not ready while a beat is in work; a finished result
// waits in the output register and does not block the input, but the next beat cannot
// finish until that result is taken.
module codon_profile_viterbi_column #(
    parameter int MAX_POSITIONS = 256,
    parameter int SCORE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,       // profile_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // position[8:0], symbol[13:9], trans_kind[16:14], score_value[48:17],
    // base_first[50:49], base_second[52:51], base_third[54:53]
    input  logic [55:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,    // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // best match score[31:0], best_position[40:32], residue_count[56:41], amino_acid[61:57]
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser     // stop_skipped
);

    localparam int SB = SCORE_BITS;
    localparam int PW = $clog2(MAX_POSITIONS + 1);
    localparam int TAW = $clog2(MAX_POSITIONS);
    localparam int EDEPTH = MAX_POSITIONS * cpv_pkg::N_AA;
    localparam int EAW = $clog2(EDEPTH);
    localparam int CW = ((PW > 9) ? PW : 9) + 1;
    localparam int XW = ((SB > 32) ? SB : 32) + 1;
    localparam logic signed [SB-1:0] SC_NEG_INF = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] SC_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [PW-1:0] J_MAX = PW'(MAX_POSITIONS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COL_INIT,
        S_COL_LOAD,
        S_POS_READ,
        S_STEP,
        S_WRITE,
        S_FINISH,
        S_DONE
    } state_t;

    // input score into the internal range
    function automatic logic signed [SB-1:0] score_in(input logic signed [31:0] v);
        logic signed [XW-1:0] ve;
        ve = XW'(v);
        if (v == 32'sh8000_0000)
            return SC_NEG_INF;
        else if (ve <= XW'(SC_NEG_INF))
            return SC_NEG_INF + SB'(1);
        else if (ve > XW'(SC_MAX))
            return SC_MAX;
        else
            return SB'(v);
    endfunction

    // internal score onto the 32 bit output
    function automatic logic [31:0] score_out(input logic signed [SB-1:0] v);
        logic signed [XW-1:0] ve;
        ve = XW'(v);
        if (v == SC_NEG_INF)
            return 32'h8000_0000;
        else if (ve < XW'(32'sh8000_0001))
            return 32'h8000_0001;
        else if (ve > XW'(32'sh7FFF_FFFF))
            return 32'h7FFF_FFFF;
        else
            return 32'(v);
    endfunction

    // input fields
    logic [8:0]  in_position;
    logic [4:0]  in_symbol;
    logic [2:0]  in_trans_kind;
    logic [31:0] in_score_value;
    logic [5:0]  in_codon;
    logic [2:0]  in_op;
    logic        accept;

    assign in_position = s_axis_tdata[8:0];
    assign in_symbol = s_axis_tdata[13:9];
    assign in_trans_kind = s_axis_tdata[16:14];
    assign in_score_value = s_axis_tdata[48:17];
    assign in_codon = {s_axis_tdata[50:49], s_axis_tdata[52:51], s_axis_tdata[54:53]};
    assign in_op = s_axis_tuser;

    state_t state_reg;
    logic [PW-1:0] j_reg;
    logic [3:0] step_reg;
    logic clr_out_reg;
    logic [8:0] profile_length_reg;
    logic [4:0] aa_reg;
    logic stop_reg;
    logic signed [SB-1:0] best_reg;
    logic [PW-1:0] best_at_reg;
    logic [15:0] count_reg;
    logic signed [SB-1:0] col_best_reg;
    logic [PW-1:0] col_at_reg;
    logic signed [SB-1:0] prev_m_reg, prev_i_reg, prev_d_reg;
    logic signed [SB-1:0] mn_prev_reg, dn_prev_reg, mn_new_reg, in_new_reg;
    logic signed [SB-1:0] tp_mm_reg, tp_im_reg, tp_dm_reg, tp_md_reg, tp_dd_reg;
    logic m_valid_reg;
    logic [63:0] m_data_reg;
    logic m_user_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    // write address checks
    logic pos_ok;
    logic [8:0] pos_m1;
    logic [EAW-1:0] pos_e;
    assign pos_ok = (in_position != 9'd0) && (CW'(in_position) <= CW'(MAX_POSITIONS));
    assign pos_m1 = in_position - 9'd1;
    assign pos_e = EAW'(pos_m1);

    // clamped profile length
    logic [PW-1:0] used_len;
    always_comb
    begin
        if (profile_length_reg == 9'd0)
            used_len = PW'(1);
        else if (CW'(profile_length_reg) > CW'(MAX_POSITIONS))
            used_len = J_MAX;
        else
            used_len = PW'(profile_length_reg);
    end

    logic in_range;
    assign in_range = (j_reg <= used_len);

    // emission memories
    logic [EAW-1:0] j_e;
    logic [EAW-1:0] em_raddr, em_waddr;
    logic [SB-1:0] em_rdata, ei_rdata;
    logic em_we, ei_we;
    logic signed [SB-1:0] wr_score;

    assign j_e = EAW'(j_reg - PW'(1));
    assign em_raddr = (j_e << 4) + (j_e << 2) + EAW'(aa_reg);
    assign em_waddr = (pos_e << 4) + (pos_e << 2) + EAW'(in_symbol);
    assign wr_score = score_in(in_score_value);
    assign em_we = accept && (in_op == cpv_pkg::OP_MATCH_WR) && pos_ok
                   && (in_symbol < 5'(cpv_pkg::N_AA));
    assign ei_we = accept && (in_op == cpv_pkg::OP_INSERT_WR) && pos_ok
                   && (in_symbol < 5'(cpv_pkg::N_AA));

    cpv_ram #(.WIDTH(SB), .DEPTH(EDEPTH)) u_match_em (
        .clk(clk), .we(em_we), .waddr(em_waddr), .wdata(wr_score),
        .raddr(em_raddr), .rdata(em_rdata)
    );

    cpv_ram #(.WIDTH(SB), .DEPTH(EDEPTH)) u_insert_em (
        .clk(clk), .we(ei_we), .waddr(em_waddr), .wdata(wr_score),
        .raddr(em_raddr), .rdata(ei_rdata)
    );

    // one transition memory per kind, read all kinds of one position at once
    logic [SB-1:0] t_rdata [cpv_pkg::N_TK];
    logic [TAW-1:0] t_raddr;
    assign t_raddr = TAW'(j_reg - PW'(1));

    for (genvar k = 0; k < cpv_pkg::N_TK; k++)
    begin : g_trans
        logic t_we;
        assign t_we = accept && (in_op == cpv_pkg::OP_TRANS_WR) && pos_ok
                      && (in_trans_kind == 3'(k));
        cpv_ram #(.WIDTH(SB), .DEPTH(MAX_POSITIONS)) u_trans (
            .clk(clk), .we(t_we), .waddr(TAW'(pos_m1)), .wdata(wr_score),
            .raddr(t_raddr), .rdata(t_rdata[k])
        );
    end

    // shared unit operands and accumulator
    logic signed [SB-1:0] alu_a, alu_b, alu_acc;

    // match, insert and delete rows, written back in place
    logic row_we;
    logic [SB-1:0] row_m_wdata, row_i_wdata, row_d_wdata;
    logic [SB-1:0] row_m_rdata, row_i_rdata, row_d_rdata;
    logic signed [SB-1:0] dn_val;

    assign dn_val = (j_reg == PW'(1)) ? SC_NEG_INF : alu_acc;
    assign row_we = (state_reg == S_CLEAR) || (state_reg == S_COL_LOAD)
                    || (state_reg == S_WRITE);

    always_comb
    begin
        row_m_wdata = SC_NEG_INF;
        row_i_wdata = SC_NEG_INF;
        row_d_wdata = SC_NEG_INF;
        if (state_reg == S_CLEAR && j_reg == PW'(0))
        begin
            row_m_wdata = '0;
        end
        else if (state_reg == S_WRITE && in_range)
        begin
            row_m_wdata = mn_new_reg;
            row_i_wdata = in_new_reg;
            row_d_wdata = dn_val;
        end
    end

    cpv_ram #(.WIDTH(SB), .DEPTH(MAX_POSITIONS + 1)) u_row_m (
        .clk(clk), .we(row_we), .waddr(j_reg), .wdata(row_m_wdata),
        .raddr(j_reg), .rdata(row_m_rdata)
    );

    cpv_ram #(.WIDTH(SB), .DEPTH(MAX_POSITIONS + 1)) u_row_i (
        .clk(clk), .we(row_we), .waddr(j_reg), .wdata(row_i_wdata),
        .raddr(j_reg), .rdata(row_i_rdata)
    );

    cpv_ram #(.WIDTH(SB), .DEPTH(MAX_POSITIONS + 1)) u_row_d (
        .clk(clk), .we(row_we), .waddr(j_reg), .wdata(row_d_wdata),
        .raddr(j_reg), .rdata(row_d_rdata)
    );

    // operand selection for the shared unit
    cpv_pkg::alu_ctl_t alu_ctl;

    always_comb
    begin
        alu_ctl.en = (state_reg == S_STEP);
        alu_ctl.use_max = 1'b0;
        alu_a = prev_m_reg;
        alu_b = tp_mm_reg;
        case (step_reg)
            4'd1:
            begin
                alu_a = prev_i_reg;
                alu_b = tp_im_reg;
                alu_ctl.use_max = 1'b1;
            end
            4'd2:
            begin
                alu_a = prev_d_reg;
                alu_b = tp_dm_reg;
                alu_ctl.use_max = 1'b1;
            end
            4'd3:
            begin
                alu_a = $signed(em_rdata);
                alu_b = (j_reg == PW'(1)) ? prev_m_reg : alu_acc;
            end
            4'd4:
            begin
                alu_a = $signed(row_m_rdata);
                alu_b = $signed(t_rdata[cpv_pkg::TK_MI]);
            end
            4'd5:
            begin
                alu_a = $signed(row_i_rdata);
                alu_b = $signed(t_rdata[cpv_pkg::TK_II]);
                alu_ctl.use_max = 1'b1;
            end
            4'd6:
            begin
                alu_a = $signed(ei_rdata);
                alu_b = alu_acc;
            end
            4'd7:
            begin
                alu_a = mn_prev_reg;
                alu_b = tp_md_reg;
            end
            4'd8:
            begin
                alu_a = dn_prev_reg;
                alu_b = tp_dd_reg;
                alu_ctl.use_max = 1'b1;
            end
            default:
            begin
                alu_a = prev_m_reg;
                alu_b = tp_mm_reg;
            end
        endcase
    end

    cpv_alu #(.SCORE_BITS(SB)) u_alu (
        .clk(clk), .ctl(alu_ctl), .a(alu_a), .b(alu_b), .acc(alu_acc)
    );

    logic [4:0] aa_next;
    assign aa_next = cpv_pkg::GENETIC_CODE[in_codon];

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_length_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            profile_length_reg <= cfg_wdata;
        end
    end

    // sequencer, column state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            j_reg <= '0;
            step_reg <= '0;
            clr_out_reg <= 1'b0;
            aa_reg <= '0;
            stop_reg <= 1'b0;
            best_reg <= SC_NEG_INF;
            best_at_reg <= '0;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && (state_reg != S_DONE))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (j_reg == J_MAX)
                    begin
                        state_reg <= clr_out_reg ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        j_reg <= j_reg + PW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        aa_reg <= '0;
                        stop_reg <= 1'b0;
                        state_reg <= S_DONE;
                        if (in_op == cpv_pkg::OP_RESTART)
                        begin
                            best_reg <= SC_NEG_INF;
                            best_at_reg <= '0;
                            count_reg <= '0;
                            j_reg <= '0;
                            clr_out_reg <= 1'b1;
                            state_reg <= S_CLEAR;
                        end
                        else if (in_op == cpv_pkg::OP_CODON)
                        begin
                            aa_reg <= aa_next;
                            if (aa_next == cpv_pkg::AA_STOP)
                            begin
                                stop_reg <= 1'b1;
                            end
                            else
                            begin
                                j_reg <= '0;
                                state_reg <= S_COL_INIT;
                            end
                        end
                    end
                end
                S_COL_INIT:
                begin
                    state_reg <= S_COL_LOAD;
                end
                S_COL_LOAD:
                begin
                    prev_m_reg <= $signed(row_m_rdata);
                    prev_i_reg <= $signed(row_i_rdata);
                    prev_d_reg <= $signed(row_d_rdata);
                    mn_prev_reg <= SC_NEG_INF;
                    dn_prev_reg <= SC_NEG_INF;
                    col_best_reg <= SC_NEG_INF;
                    col_at_reg <= best_at_reg;
                    j_reg <= PW'(1);
                    state_reg <= S_POS_READ;
                end
                S_POS_READ:
                begin
                    step_reg <= '0;
                    state_reg <= in_range ? S_STEP : S_WRITE;
                end
                S_STEP:
                begin
                    if (step_reg == 4'd4)
                    begin
                        mn_new_reg <= alu_acc;
                    end
                    if (step_reg == 4'd7)
                    begin
                        in_new_reg <= alu_acc;
                    end
                    if (step_reg == 4'd8)
                    begin
                        state_reg <= S_WRITE;
                    end
                    step_reg <= step_reg + 4'd1;
                end
                S_WRITE:
                begin
                    prev_m_reg <= $signed(row_m_rdata);
                    prev_i_reg <= $signed(row_i_rdata);
                    prev_d_reg <= $signed(row_d_rdata);
                    mn_prev_reg <= $signed(row_m_wdata);
                    dn_prev_reg <= $signed(row_d_wdata);
                    tp_mm_reg <= $signed(t_rdata[cpv_pkg::TK_MM]);
                    tp_im_reg <= $signed(t_rdata[cpv_pkg::TK_IM]);
                    tp_dm_reg <= $signed(t_rdata[cpv_pkg::TK_DM]);
                    tp_md_reg <= $signed(t_rdata[cpv_pkg::TK_MD]);
                    tp_dd_reg <= $signed(t_rdata[cpv_pkg::TK_DD]);
                    if (in_range && (mn_new_reg > col_best_reg))
                    begin
                        col_best_reg <= mn_new_reg;
                        col_at_reg <= j_reg;
                    end
                    if (j_reg == J_MAX)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        j_reg <= j_reg + PW'(1);
                        state_reg <= S_POS_READ;
                    end
                end
                S_FINISH:
                begin
                    if (!(best_reg > col_best_reg))
                    begin
                        best_reg <= col_best_reg;
                        best_at_reg <= col_at_reg;
                    end
                    if (count_reg != 16'hFFFF)
                    begin
                        count_reg <= count_reg + 16'd1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg <= {2'b00, aa_reg, count_reg, 9'(best_at_reg),
                                       score_out(best_reg)};
                        m_user_reg <= stop_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;
    assign m_axis_tuser = m_user_reg;

    // an accepted beat always takes the block out of the idle state
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    // position counter stays inside the rows
    a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
        j_reg <= J_MAX)
        else $error("position counter beyond the profile");

    // best position never lies beyond the last profile position
    a_best_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        best_at_reg <= J_MAX)
        else $error("best position beyond the profile");

endmodule

// File: tb/codon_profile_viterbi_column_tb.sv
// testbench of the codon profile viterbi column block: self-checking stream test
`timescale 1ns / 100ps

module codon_profile_viterbi_column_tb;

    localparam int NPOS = 256;
    localparam int NLOAD = 6;
    localparam longint NEG_INF = -64'sd2147483648;
    localparam longint SCORE_MAX = 64'sd2147483647;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int SETTLE = 400;
    localparam int HOLD_CYCLES = 3000;

    // standard genetic code, first*16 + second*4 + third
    localparam logic [4:0] CODON_TO_AA [64] = '{
        5'd8, 5'd11, 5'd8, 5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
        5'd14, 5'd15, 5'd14, 5'd15, 5'd7, 5'd7, 5'd10, 5'd7,
        5'd13, 5'd6, 5'd13, 5'd6, 5'd12, 5'd12, 5'd12, 5'd12,
        5'd14, 5'd14, 5'd14, 5'd14, 5'd9, 5'd9, 5'd9, 5'd9,
        5'd3, 5'd2, 5'd3, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0,
        5'd5, 5'd5, 5'd5, 5'd5, 5'd17, 5'd17, 5'd17, 5'd17,
        5'd20, 5'd19, 5'd20, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15,
        5'd20, 5'd1, 5'd18, 5'd1, 5'd9, 5'd4, 5'd9, 5'd4
    };

    typedef struct {
        logic [31:0] top_score;
        logic [8:0]  best_position;
        logic [15:0] residue_count;
        logic [4:0]  amino_acid;
        logic        stop_skipped;
    } column_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    codon_profile_viterbi_column dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // predictor state
    int unsigned     len_reg;
    longint          match_col [0:NPOS];
    longint          insert_col [0:NPOS];
    longint          delete_col [0:NPOS];
    longint          next_m [0:NPOS];
    longint          next_i [0:NPOS];
    longint          next_d [0:NPOS];
    longint          match_emit [NPOS*cpv_pkg::N_AA];
    longint          insert_emit [NPOS*cpv_pkg::N_AA];
    longint          trans_score [NPOS*cpv_pkg::N_TK];
    longint          run_best;
    int unsigned     best_at;
    int unsigned     scored;

    column_result_t  pending_results [$];
    bit              failed;
    bit              idle_on;
    int              hold_requests;
    int              beats_out;
    int              cycles;

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** codon_profile_viterbi_column: FAILED **");
            $finish;
        end
    end

    function automatic longint sat_add(longint a, longint b);
        longint s;
        if (a == NEG_INF || b == NEG_INF)
            return NEG_INF;
        s = a + b;
        if (s < NEG_INF)
            return NEG_INF;
        if (s > SCORE_MAX)
            return SCORE_MAX;
        return s;
    endfunction

    function automatic longint max_of(longint a, longint b);
        return a > b ? a : b;
    endfunction

    function automatic longint tr(int unsigned p, int k);
        return trans_score[(p - 1) * cpv_pkg::N_TK + k];
    endfunction

    function automatic void restart_rows();
        for (int j = 0; j <= NPOS; j++)
        begin
            match_col[j] = NEG_INF;
            insert_col[j] = NEG_INF;
            delete_col[j] = NEG_INF;
        end
        match_col[0] = 0;
        run_best = NEG_INF;
        best_at = 0;
        scored = 0;
    endfunction

    // one viterbi column for residue aa
    function automatic void score_column(int aa);
        int unsigned n;
        longint col_best;
        int unsigned col_at;
        longint from;
        n = (len_reg < 1) ? 1 : (len_reg > NPOS ? NPOS : len_reg);
        col_best = NEG_INF;
        col_at = best_at;
        for (int j = 0; j <= NPOS; j++)
        begin
            next_m[j] = NEG_INF;
            next_i[j] = NEG_INF;
            next_d[j] = NEG_INF;
        end
        for (int unsigned j = 1; j <= n; j++)
        begin
            if (j == 1)
                from = match_col[0];
            else
            begin
                from = sat_add(match_col[j-1], tr(j-1, cpv_pkg::TK_MM));
                from = max_of(from, sat_add(insert_col[j-1], tr(j-1, cpv_pkg::TK_IM)));
                from = max_of(from, sat_add(delete_col[j-1], tr(j-1, cpv_pkg::TK_DM)));
            end
            next_m[j] = sat_add(match_emit[(j-1)*cpv_pkg::N_AA + aa], from);
            if (next_m[j] > col_best)
            begin
                col_best = next_m[j];
                col_at = j;
            end
        end
        for (int unsigned j = 1; j <= n; j++)
        begin
            from = max_of(sat_add(match_col[j], tr(j, cpv_pkg::TK_MI)),
                          sat_add(insert_col[j], tr(j, cpv_pkg::TK_II)));
            next_i[j] = sat_add(insert_emit[(j-1)*cpv_pkg::N_AA + aa], from);
        end
        for (int unsigned j = 2; j <= n; j++)
            next_d[j] = max_of(sat_add(next_m[j-1], tr(j-1, cpv_pkg::TK_MD)),
                               sat_add(next_d[j-1], tr(j-1, cpv_pkg::TK_DD)));
        match_col = next_m;
        insert_col = next_i;
        delete_col = next_d;
        if (!(run_best > col_best))
        begin
            run_best = col_best;
            best_at = col_at & 9'h1FF;
        end
        if (scored < 65535)
            scored++;
    endfunction

    // apply one accepted beat and queue its result
    function automatic void predict_beat(logic [2:0] op, logic [8:0] pos, logic [4:0] sym,
                                         logic [2:0] kind, logic [31:0] score,
                                         logic [5:0] codon);
        column_result_t r;
        longint v;
        bit pos_ok;
        pos_ok = (pos >= 1 && pos <= NPOS);
        v = (score == 32'h8000_0000) ? NEG_INF : longint'($signed(score));
        r.amino_acid = '0;
        r.stop_skipped = 1'b0;
        case (op)
            cpv_pkg::OP_MATCH_WR:
                if (pos_ok && sym < cpv_pkg::N_AA)
                    match_emit[(pos-1)*cpv_pkg::N_AA + sym] = v;
            cpv_pkg::OP_INSERT_WR:
                if (pos_ok && sym < cpv_pkg::N_AA)
                    insert_emit[(pos-1)*cpv_pkg::N_AA + sym] = v;
            cpv_pkg::OP_TRANS_WR:
                if (pos_ok && kind < cpv_pkg::N_TK)
                    trans_score[(pos-1)*cpv_pkg::N_TK + kind] = v;
            cpv_pkg::OP_RESTART:
                restart_rows();
            cpv_pkg::OP_CODON:
            begin
                r.amino_acid = CODON_TO_AA[codon];
                if (r.amino_acid == cpv_pkg::AA_STOP)
                    r.stop_skipped = 1'b1;
                else
                    score_column(r.amino_acid);
            end
            default: ;
        endcase
        r.top_score = run_best[31:0];
        r.best_position = best_at[8:0];
        r.residue_count = scored[15:0];
        pending_results.insert(pending_results.size(), r);
    endfunction

    // send one beat, gap drawn per beat
    task automatic send_beat(logic [2:0] op, logic [8:0] pos, logic [4:0] sym,
                             logic [2:0] kind, logic [31:0] score, logic [5:0] codon);
        int gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {1'b0, codon[1:0], codon[3:2], codon[5:4], score, kind, sym, pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_beat(op, pos, sym, kind, score, codon);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_length(int unsigned v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v[8:0];
        len_reg = v & 9'h1FF;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_score();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0001;
            3: return $urandom();
            default: return $urandom_range(0, 4000) - 2000;
        endcase
    endfunction

    // mostly codons and valid writes, some bad addresses, unknown ops and restarts
    task automatic send_random();
        int pick;
        logic [8:0] pos;
        logic [4:0] sym;
        logic [2:0] kind;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        pos = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(1, 12));
        sym = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, 19));
        kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 6));
        if (pick < 55)
            op = cpv_pkg::OP_CODON;
        else if (pick < 68)
            op = cpv_pkg::OP_MATCH_WR;
        else if (pick < 78)
            op = cpv_pkg::OP_INSERT_WR;
        else if (pick < 91)
            op = cpv_pkg::OP_TRANS_WR;
        else if (pick < 95)
            op = cpv_pkg::OP_RESTART;
        else
            op = 3'($urandom_range(5, 7));
        send_beat(op, pos, sym, kind, rand_score(), 6'($urandom_range(0, 63)));
    endtask

    // result checker
    always @(posedge clk)
    begin
        column_result_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            beats_out <= beats_out + 1;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                failed = 1'b1;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== e.top_score)
                begin
                    $error("best score expected %0d got %0d",
                           $signed(e.top_score), $signed(m_axis_tdata[31:0]));
                    failed = 1'b1;
                end
                if (m_axis_tdata[40:32] !== e.best_position)
                begin
                    $error("best_position expected %0d got %0d",
                           e.best_position, m_axis_tdata[40:32]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[56:41] !== e.residue_count)
                begin
                    $error("residue_count expected %0d got %0d",
                           e.residue_count, m_axis_tdata[56:41]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[61:57] !== e.amino_acid)
                begin
                    $error("amino_acid expected %0d got %0d",
                           e.amino_acid, m_axis_tdata[61:57]);
                    failed = 1'b1;
                end
                if (m_axis_tuser !== e.stop_skipped)
                begin
                    $error("stop_skipped expected %0d got %0d", e.stop_skipped, m_axis_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    // receiver ready: per-beat stall draw plus a long hold-off on request
    always @(negedge clk)
    begin
        int seen;
        int wait_left;
        int hold_seen;
        int hold_left;
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (beats_out != seen)
        begin
            seen = beats_out;
            wait_left = idle_on ? $urandom_range(0, 13) : 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (wait_left > 0)
        begin
            wait_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // idle-time beats: unknown ops, stop codons, restart
    task automatic test_reset_state();
        send_beat(3'd5, 9'd0, 5'd0, 3'd0, 32'h0, 6'd0);
        send_beat(3'd7, 9'h1FF, 5'h1F, 3'd7, 32'hFFFF_FFFF, 6'h3F);
        send_beat(cpv_pkg::OP_CODON, 9'd0, 5'd0, 3'd0, 32'h0, 6'b110000);
        send_beat(cpv_pkg::OP_RESTART, 9'd0, 5'd0, 3'd0, 32'h0, 6'd0);
    endtask

    // every entry of the scored positions written once, no scored position reads an unwritten entry
    task automatic test_table_load();
        idle_on = 1'b0;
        for (int p = 1; p <= NLOAD; p++)
        begin
            for (int a = 0; a < cpv_pkg::N_AA; a++)
            begin
                send_beat(cpv_pkg::OP_MATCH_WR, p[8:0], a[4:0], 3'd0,
                          $urandom_range(0, 2000) - 1500, 6'd0);
                send_beat(cpv_pkg::OP_INSERT_WR, p[8:0], a[4:0], 3'd0,
                          $urandom_range(0, 2000) - 1500, 6'd0);
            end
            for (int k = 0; k < cpv_pkg::N_TK; k++)
                send_beat(cpv_pkg::OP_TRANS_WR, p[8:0], 5'd0, k[2:0],
                          $urandom_range(0, 1000) - 900, 6'd0);
        end
        idle_on = 1'b1;
    endtask

    // field extremes, saturation, bad addresses, the TAG and TGA stop codons
    task automatic test_directed();
        set_length(2);
        send_beat(cpv_pkg::OP_MATCH_WR, 9'd1, 5'd8, 3'd0, 32'h7FFF_FFFF, 6'd0);
        send_beat(cpv_pkg::OP_MATCH_WR, 9'd2, 5'd8, 3'd0, 32'h7FFF_FFFF, 6'd0);
        send_beat(cpv_pkg::OP_TRANS_WR, 9'd1, 5'd0, 3'(cpv_pkg::TK_MM), 32'h7FFF_FFFF, 6'd0);
        send_beat(cpv_pkg::OP_CODON, 9'd0, 5'd0, 3'd0, 32'h0, 6'b000000);
        send_beat(cpv_pkg::OP_CODON, 9'd0, 5'd0, 3'd0, 32'h0, 6'b000000);
        send_beat(cpv_pkg::OP_INSERT_WR, 9'd2, 5'd19, 3'd0, 32'h8000_0000, 6'd0);
        send_beat(cpv_pkg::OP_TRANS_WR, 9'd2, 5'd0, 3'(cpv_pkg::TK_DD), 32'h8000_0001, 6'd0);
        send_beat(cpv_pkg::OP_MATCH_WR, 9'd0, 5'd3, 3'd0, 32'h1234, 6'd0);
        send_beat(cpv_pkg::OP_MATCH_WR, 9'd257, 5'd3, 3'd0, 32'h1234, 6'd0);
        send_beat(cpv_pkg::OP_INSERT_WR, 9'd1, 5'd20, 3'd0, 32'h1234, 6'd0);
        send_beat(cpv_pkg::OP_TRANS_WR, 9'd1, 5'd0, 3'd7, 32'h1234, 6'd0);
        send_beat(cpv_pkg::OP_TRANS_WR, 9'd256, 5'd31, 3'(cpv_pkg::TK_MI), 32'hFFFF_FF00,
                  6'd0);
        send_beat(cpv_pkg::OP_CODON, 9'd0, 5'd0, 3'd0, 32'h0, 6'b111111);
        send_beat(cpv_pkg::OP_CODON, 9'd0, 5'd0, 3'd0, 32'h0, 6'b110010);
        send_beat(cpv_pkg::OP_CODON, 9'd0, 5'd0, 3'd0, 32'h0, 6'b111000);
        send_beat(3'd6, 9'd1, 5'd1, 3'd1, 32'h0, 6'd4);
        send_beat(cpv_pkg::OP_RESTART, 9'd0, 5'd0, 3'd0, 32'h0, 6'd0);
        send_beat(cpv_pkg::OP_CODON, 9'd0, 5'd0, 3'd0, 32'h0, 6'b101010);
        send_beat(cpv_pkg::OP_CODON, 9'd0, 5'd0, 3'd0, 32'h0, 6'b010101);
    endtask

    // random mix over several profile lengths, zero length included
    task automatic test_random();
        int unsigned lengths [8] = '{1, 0, 6, 3, 5, 2, 4, 6};
        int unsigned counts [8] = '{20, 15, 40, 25, 40, 20, 30, 40};
        for (int s = 0; s < 8; s++)
        begin
            set_length(lengths[s]);
            send_beat(cpv_pkg::OP_RESTART, 9'd0, 5'd0, 3'd0, 32'h0, 6'd0);
            idle_on = (s % 3) != 2;
            repeat (counts[s]) send_random();
        end
        idle_on = 1'b1;
    endtask

    // long receiver hold-off while codons keep coming
    task automatic test_backpressure();
        set_length(4);
        hold_requests++;
        repeat (8) send_beat(cpv_pkg::OP_CODON, 9'd0, 5'd0, 3'd0, 32'h0,
                             6'($urandom_range(0, 47)));
        repeat (4) send_random();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        idle_on = 1'b1;
        len_reg = NPOS;
        for (int i = 0; i < NPOS*cpv_pkg::N_AA; i++)
        begin
            match_emit[i] = 0;
            insert_emit[i] = 0;
        end
        for (int i = 0; i < NPOS*cpv_pkg::N_TK; i++)
            trans_score[i] = 0;
        restart_rows();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_table_load();
        test_directed();
        test_random();
        test_backpressure();
        drain();

        if (!failed)
            $display("** codon_profile_viterbi_column: PASSED **");
        else
            $display("** codon_profile_viterbi_column: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
sv/cpv_pkg.sv
sv/cpv_ram.sv
sv/cpv_alu.sv
sv/codon_profile_viterbi_column.sv
tb/codon_profile_viterbi_column_tb.sv
